[rtl/affine_point_transform_defines.svh]
// assertion macros shared by the checker of affine_point_transform
// depends on nothing; included by the files that hold assertions
`ifndef AFFINE_POINT_TRANSFORM_DEFINES_SVH
`define AFFINE_POINT_TRANSFORM_DEFINES_SVH

// same-cycle implication, off while reset is high
`define APT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apt: %s failed", "lbl");

// next-cycle implication, off while reset is high
`define APT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apt: %s failed", "lbl");

// what must hold in the cycle after reset
`define APT_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("apt: %s failed", "lbl");

`endif

[rtl/apt_pkg.sv]
// types, constants and codes of the affine point transform
// depends on nothing; used by every module of the block
`default_nettype none

package apt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIM       = 4;
  localparam int IDX_W     = $clog2(DIM);
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int N_OUT     = 3;

  localparam logic signed [DATA_W-1:0] FIX_ONE     = DATA_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [DATA_W-1:0] FIX_NEG_ONE = -FIX_ONE;
  localparam logic signed [DATA_W-1:0] SAT_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN     = {1'b1, {(DATA_W-1){1'b0}}};

  // operation codes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_XFORM = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  typedef struct packed {
    logic        [1:0]        mode;
    logic        [2:0]        row;
    logic        [2:0]        col;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] pz;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    logic signed [DATA_W-1:0] rz;
    logic signed [DATA_W-1:0] read_value;
    logic        [1:0]        status;
  } res_t;

  // rows 0..2 of the matrix, as the transform sees them
  typedef logic [N_OUT-1:0][DIM-1:0][DATA_W-1:0] xf_rows_t;

  // products stage: nine products, three translations, side data
  typedef struct packed {
    logic                                   xform;
    logic [1:0]                             status;
    logic [DATA_W-1:0]                      read_value;
    logic [N_OUT-1:0][N_OUT-1:0][PROD_W-1:0] prod;
    logic [N_OUT-1:0][DATA_W-1:0]           trans;
  } prod_t;

endpackage

`default_nettype wire

[rtl/apt_matrix.sv]
// 4x4 matrix element store, resets to identity
// depends on apt_pkg
`default_nettype none

module apt_matrix (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              wr_en,
  input  wire  [apt_pkg::IDX_W-1:0]        wr_row,
  input  wire  [apt_pkg::IDX_W-1:0]        wr_col,
  input  wire  [apt_pkg::DATA_W-1:0]       wr_data,
  input  wire  [apt_pkg::IDX_W-1:0]        rd_row,
  input  wire  [apt_pkg::IDX_W-1:0]        rd_col,
  output logic [apt_pkg::DATA_W-1:0]       rd_data,
  output apt_pkg::xf_rows_t                rows
);
  import apt_pkg::*;

  logic [DIM*DIM-1:0][DATA_W-1:0] mat;

  // element writes, identity on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIM * DIM; i++) begin
        mat[i] <= ((i / DIM) == (i % DIM)) ? FIX_ONE : '0;
      end
    end else if (wr_en) begin
      mat[{wr_row, wr_col}] <= wr_data;
    end
  end

  // element read for read beats
  assign rd_data = mat[{rd_row, rd_col}];

  // fixed taps of rows 0..2 for the transform
  always_comb begin
    for (int r = 0; r < N_OUT; r++) begin
      for (int c = 0; c < DIM; c++) begin
        rows[r][c] = mat[r * DIM + c];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/apt_mul.sv]
// products stage: nine 32x32 products, read data and index status
// depends on apt_pkg
`default_nettype none

module apt_mul (
  input  wire                         clk,
  input  wire                         en,
  input  apt_pkg::cmd_t               cmd,
  input  apt_pkg::xf_rows_t           rows,
  input  wire  [apt_pkg::DATA_W-1:0]  rd_data,
  output apt_pkg::prod_t              stage
);
  import apt_pkg::*;

  logic                     idx_ok;
  logic signed [DATA_W-1:0] pt [N_OUT];
  prod_t                    stage_next;

  assign idx_ok = (cmd.row[2] == 1'b0) && (cmd.col[2] == 1'b0);
  assign pt[0]  = cmd.px;
  assign pt[1]  = cmd.py;
  assign pt[2]  = cmd.pz;

  // products and side data for the next stage
  always_comb begin
    stage_next            = '0;
    stage_next.xform      = (cmd.mode == MODE_XFORM);
    for (int r = 0; r < N_OUT; r++) begin
      for (int c = 0; c < N_OUT; c++) begin
        stage_next.prod[r][c] = PROD_W'($signed(rows[r][c])) * PROD_W'(pt[c]);
      end
      stage_next.trans[r] = rows[r][N_OUT];
    end
    case (cmd.mode)
      MODE_WRITE: begin
        stage_next.status = idx_ok ? STATUS_OK : STATUS_RANGE;
      end
      MODE_READ: begin
        stage_next.status     = idx_ok ? STATUS_OK : STATUS_RANGE;
        stage_next.read_value = idx_ok ? rd_data : FIX_NEG_ONE;
      end
      default: begin
        stage_next.status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

[rtl/apt_sum.sv]
// sum stage: full-width sum, floor shift, saturation, result register
// depends on apt_pkg
`default_nettype none

module apt_sum (
  input  wire             clk,
  input  wire             en,
  input  apt_pkg::prod_t  stage,
  output apt_pkg::res_t   res
);
  import apt_pkg::*;

  logic signed [SUM_W-1:0]  sum     [N_OUT];
  logic signed [SUM_W-1:0]  shifted [N_OUT];
  logic signed [DATA_W-1:0] coord   [N_OUT];
  logic        [N_OUT-1:0]  sat;
  res_t                     res_next;

  // per output row: exact sum, arithmetic shift is floor, then clamp
  always_comb begin
    for (int r = 0; r < N_OUT; r++) begin
      sum[r] = SUM_W'($signed(stage.prod[r][0]))
             + SUM_W'($signed(stage.prod[r][1]))
             + SUM_W'($signed(stage.prod[r][2]))
             + (SUM_W'($signed(stage.trans[r])) <<< FRAC_BITS);
      shifted[r] = sum[r] >>> FRAC_BITS;
      // fits when all bits from the sign of a 32-bit word upward agree
      sat[r] = !((&shifted[r][SUM_W-1:DATA_W-1]) || !(|shifted[r][SUM_W-1:DATA_W-1]));
      if (!sat[r]) begin
        coord[r] = shifted[r][DATA_W-1:0];
      end else if (shifted[r][SUM_W-1]) begin
        coord[r] = SAT_MIN;
      end else begin
        coord[r] = SAT_MAX;
      end
    end
  end

  // result assembly by operation
  always_comb begin
    res_next            = '0;
    res_next.read_value = stage.read_value;
    res_next.status     = stage.status;
    if (stage.xform) begin
      res_next.rx     = coord[0];
      res_next.ry     = coord[1];
      res_next.rz     = coord[2];
      res_next.status = (|sat) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

[rtl/affine_point_transform.sv]
// top level of the affine point transform: three-stage pipeline
// depends on apt_pkg, apt_matrix, apt_mul, apt_sum
//
//   channel  signals                      beat carries
//   cmd      cmd_valid, cmd_ready, cmd    write / read element, or a point
//   res      res_valid, res_ready, res    one result per cmd beat
//
// one beat per cycle while res is not stalled; each cmd beat passes in turn through
// the input register, product register and result register
// the nine 32x32 multipliers and the 66-bit sum each sit in their own stage
// a write is seen by the very next beat, reads and transforms included
// reset returns the matrix to identity and empties the pipeline at once
// a stalled res side holds the result; stages behind it close up bubbles,
// and cmd_ready drops only when all three are full
`default_nettype none

module affine_point_transform (
  input  wire            clk,
  input  wire            rst,
  input  wire            cmd_valid,
  output logic           cmd_ready,
  input  apt_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  wire            res_ready,
  output apt_pkg::res_t  res
);
  import apt_pkg::*;

  logic              v1;
  logic              v2;
  logic              en1;
  logic              en2;
  logic              en3;
  cmd_t              cmd_q;
  logic              wr_en;
  logic [DATA_W-1:0] rd_data;
  xf_rows_t          rows;
  prod_t             stage;

  // stage enables, from the result side back to the input
  assign en3       = !res_valid || res_ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign cmd_ready = en1;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= cmd_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        res_valid <= v2;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en1 && cmd_valid) begin
      cmd_q <= cmd;
    end
  end

  // store a valid element as the write beat leaves the input register
  assign wr_en = v1 && en2 && (cmd_q.mode == MODE_WRITE)
              && (cmd_q.row[2] == 1'b0) && (cmd_q.col[2] == 1'b0);

  apt_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_row  (cmd_q.row[IDX_W-1:0]),
    .wr_col  (cmd_q.col[IDX_W-1:0]),
    .wr_data (cmd_q.value),
    .rd_row  (cmd_q.row[IDX_W-1:0]),
    .rd_col  (cmd_q.col[IDX_W-1:0]),
    .rd_data (rd_data),
    .rows    (rows)
  );

  apt_mul u_mul (
    .clk     (clk),
    .en      (en2),
    .cmd     (cmd_q),
    .rows    (rows),
    .rd_data (rd_data),
    .stage   (stage)
  );

  apt_sum u_sum (
    .clk   (clk),
    .en    (en3),
    .stage (stage),
    .res   (res)
  );

endmodule

`default_nettype wire

[rtl/apt_checker.sv]
// port-level checks of affine_point_transform, bound to the top level
// depends on apt_pkg and affine_point_transform_defines.svh
`default_nettype none

`include "affine_point_transform_defines.svh"

module apt_checker (
  input wire            clk,
  input wire            rst,
  input wire            res_valid,
  input wire            res_ready,
  input apt_pkg::res_t  res
);
  import apt_pkg::*;

  // pipeline is empty after reset
  `APT_ASSERT_RESET(a_empty_after_reset, !res_valid)

  // a stalled result beat stays put
  `APT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

  // status never takes the unused code
  `APT_ASSERT_IMPL(a_status_code, res_valid,
                   res.status == STATUS_OK || res.status == STATUS_RANGE ||
                   res.status == STATUS_SAT)

  // index errors come from element beats and carry no point
  `APT_ASSERT_IMPL(a_range_no_point, res_valid && res.status == STATUS_RANGE,
                   res.rx == '0 && res.ry == '0 && res.rz == '0)

  // a saturated beat is a transform and reads nothing back
  `APT_ASSERT_IMPL(a_sat_no_read, res_valid && res.status == STATUS_SAT,
                   res.read_value == '0)

endmodule

bind affine_point_transform apt_checker u_apt_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

`default_nettype wire
